// ----- rtl/csn_pkg.sv -----
// Shared types, constants and helpers for the column statistics normalizer.
// Used by csn_div and column_stats_normalizer; depends on nothing.
package csn_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int DIV_W       = 80;

  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_EPS  = 1'b1;

  typedef enum logic [2:0] {
    CMD_ACC     = 3'd0,
    CMD_FIN     = 3'd1,
    CMD_SCALE   = 3'd2,
    CMD_UPSCALE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_MEAN   = 2'd1,
    MODE_MINMAX = 2'd2,
    MODE_STD    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         column;
    logic signed [31:0] sample_value;
    logic               value_missing;
    logic               keep_scaling;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [15:0]        count_out;
    logic signed [31:0] mean_out;
    logic [30:0]        stdev_out;
    logic signed [31:0] min_out;
    logic signed [31:0] max_out;
    logic               overflow;
  } out_word_t;

  // accumulator entry
  typedef struct packed {
    logic [15:0] cnt;
    logic [47:0] sum;
    logic [63:0] sqsum;
    logic [31:0] lo;
    logic [31:0] hi;
  } acc_word_t;

  // finalized statistics entry
  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] sd;
    logic [31:0] inv_rng;
    logic [31:0] inv_sd;
    logic [31:0] flr_rng;
    logic [31:0] flr_sd;
  } stat_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [31:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    s.ov = 1'b0;
    if (v > 66'sd2147483647) begin
      s.ov  = 1'b1;
      s.val = MAX32;
    end else if (v < -66'sd2147483648) begin
      s.ov  = 1'b1;
      s.val = MIN32;
    end else begin
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

// ----- rtl/csn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module csn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/csn_div.sv -----
// Restoring divider, one quotient bit per cycle; a new start is ignored while busy.
// Depends on csn_pkg for the request/response structs.
module csn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  csn_pkg::div_req_t  req,
  output csn_pkg::div_rsp_t  rsp
);
  import csn_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [32:0]      sh;
  logic             fit;

  assign sh  = {rem_r, q_r[DIV_W-1]};
  assign fit = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        q_r    <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= fit ? 32'(sh - {1'b0, den_r}) : sh[31:0];
        q_r   <= {q_r[DIV_W-2:0], fit};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1)) |=> done_r) else $error("divider missed done");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r))) else $error("stray divider done");

endmodule

// ----- rtl/column_stats_normalizer.sv -----
// Top level: per-column statistics, finalize and normalization sequencer.
// Depends on csn_pkg, csn_ram (two state memories) and csn_div.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------
//  input    | start / busy                 | in_data  (in_word_t)
//  result   | out_valid strobe, 1 cycle    | out_data (out_word_t)
//  config   | psel penable pwrite pready   | paddr pwdata prdata
//
// Clear, unknown commands, missing samples, mode none and short or disabled finalize pass
// S_RD, S_CMD and S_WB; accumulate adds S_AMUL and S_AUPD, scale/upscale S_SMUL and S_SUPD;
// full finalize is set by five serial divisions and the 32-step square root.
// One item is in flight at a time, so memory read-after-write is safe.
// After reset a clearing pass writes every column, with busy high.
// The receiver cannot stall; each result strobes for exactly one cycle.
module column_stats_normalizer #(
  parameter int COLUMNS = csn_pkg::COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  csn_pkg::in_word_t  in_data,
  output logic               out_valid,
  output csn_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import csn_pkg::*;

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_CMD, S_AMUL, S_AUPD, S_SMUL, S_SUPD,
    S_F1, S_F2, S_F3, S_F4, S_FDM, S_FDT, S_FDV, S_SQ, S_FFL,
    S_FDR, S_FDS, S_WB
  } state_t;

  state_t state_r;

  // configuration
  logic [1:0]  mode_r;
  logic [16:0] eps_r;

  // item and working copy of the column
  in_word_t           in_r;
  logic               bad_r;
  logic [AW-1:0]      clr_r;
  logic [15:0]        cnt_r;
  logic [47:0]        sum_r;
  logic [63:0]        sq_r;
  logic signed [31:0] lo_r, hi_r, mean_r;
  logic [31:0]        sd_r, ir_r, is_r, fr_r, fs_r;
  logic [31:0]        res_r;
  logic               ov_r;
  logic [95:0]        p_r;
  logic [63:0]        x_r, root_r;
  logic [4:0]         k_r;
  logic               sc_neg_r, sc_hi_r;
  logic [31:0]        sc_mag_r, sc_fac_r;
  logic signed [31:0] sc_base_r;
  logic [63:0]        prod_r;
  logic               out_valid_r;
  out_word_t          out_r;

  // memories
  acc_word_t  acc_rd, acc_wdata, acc_clr;
  stat_word_t stat_rd, stat_wdata, stat_clr;
  logic       mem_we;
  logic [AW-1:0] waddr, raddr;

  assign acc_clr  = '{cnt: '0, sum: '0, sqsum: '0, lo: MAX32, hi: MIN32};
  assign stat_clr = '{mean: '0, sd: '0, inv_rng: ONE_Q, inv_sd: ONE_Q,
                      flr_rng: ONE_Q, flr_sd: ONE_Q};

  assign mem_we = (state_r == S_CLR) || (state_r == S_WB && !bad_r);
  assign waddr  = (state_r == S_CLR) ? clr_r : AW'(in_r.column);
  assign raddr  = AW'(in_data.column);
  assign acc_wdata  = (state_r == S_CLR) ? acc_clr :
                      acc_word_t'{cnt: cnt_r, sum: sum_r, sqsum: sq_r, lo: lo_r, hi: hi_r};
  assign stat_wdata = (state_r == S_CLR) ? stat_clr :
                      stat_word_t'{mean: mean_r, sd: sd_r, inv_rng: ir_r, inv_sd: is_r,
                                   flr_rng: fr_r, flr_sd: fs_r};

  csn_ram #(.WIDTH($bits(acc_word_t)), .DEPTH(COLUMNS)) u_acc_ram (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(acc_wdata),
    .raddr(raddr), .rdata(acc_rd)
  );

  csn_ram #(.WIDTH($bits(stat_word_t)), .DEPTH(COLUMNS)) u_stat_ram (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(stat_wdata),
    .raddr(raddr), .rdata(stat_rd)
  );

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  csn_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // common terms
  logic signed [31:0] v;
  logic [31:0]        vmag;
  logic [47:0]        smag;
  logic               col_ok;
  logic [31:0]        eps32, rng, fr_c, fs_c;
  logic [32:0]        rng33;
  logic [63:0]        t_c, vnum_c, var_c;
  logic [31:0]        mul_a, mul_b;

  assign v      = in_r.sample_value;
  assign vmag   = v[31] ? (32'd0 - v) : v;
  assign smag   = sum_r[47] ? (48'd0 - sum_r) : sum_r;
  assign col_ok = 32'(in_data.column) < 32'(COLUMNS);
  assign eps32  = (eps_r == '0) ? 32'd1 : 32'(eps_r);
  assign rng33  = {hi_r[31], hi_r} - {lo_r[31], lo_r};
  assign rng    = rng33[32] ? 32'd0 : rng33[31:0];
  assign fr_c   = (rng > eps32) ? rng : eps32;
  assign fs_c   = (sd_r > eps32) ? sd_r : eps32;
  assign t_c    = div_rsp.quot[63:0];
  assign vnum_c = (sq_r > t_c) ? (sq_r - t_c) : 64'd0;
  assign var_c  = div_rsp.quot[63:0];

  // shared 32x32 multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_AMUL: begin mul_a = vmag; mul_b = vmag; end
      S_F1:   begin mul_a = smag[31:0]; mul_b = smag[31:0]; end
      S_F2:   begin mul_a = 32'(smag[47:32]); mul_b = smag[31:0]; end
      S_F3:   begin mul_a = 32'(smag[47:32]); mul_b = 32'(smag[47:32]); end
      S_SMUL: begin mul_a = sc_mag_r; mul_b = sc_fac_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      S_F4: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(smag) + DIV_W'(cnt_r >> 1);
        div_req.den   = 32'(cnt_r);
      end
      S_FDM: begin
        div_req.start = div_rsp.done;
        div_req.num   = p_r[95:16];
        div_req.den   = 32'(cnt_r);
      end
      S_FDT: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_W'(vnum_c);
        div_req.den   = 32'(cnt_r - 16'd1);
      end
      S_FFL: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(33'h1_0000_0000 + 33'(fr_c >> 1));
        div_req.den   = fr_c;
      end
      S_FDR: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_W'(33'h1_0000_0000 + 33'(fs_r >> 1));
        div_req.den   = fs_r;
      end
      default: div_req = '0;
    endcase
  end

  // square root step
  logic [63:0] bitv, trial, x_nxt, root_nxt;
  always_comb begin
    bitv  = 64'd1 << {k_r, 1'b0};
    trial = root_r + bitv;
    if (x_r >= trial) begin
      x_nxt    = x_r - trial;
      root_nxt = (root_r >> 1) + bitv;
    end else begin
      x_nxt    = x_r;
      root_nxt = root_r >> 1;
    end
  end

  // scale / upscale operands and final product
  logic [1:0]         mode;
  logic signed [31:0] base_c;
  logic [32:0]        a33, amag;
  logic [65:0]        sc_sum, sc_r, sc_t;
  sat_t               sc_sat, mean_sat;
  logic [65:0]        q66;

  assign mode   = mode_r;
  assign base_c = (mode == MODE_MINMAX) ? lo_r : mean_r;
  assign a33    = {v[31], v} - {base_c[31], base_c};
  assign amag   = a33[32] ? (33'd0 - a33) : a33;
  assign sc_sum = 66'(prod_r) + (sc_hi_r ? (66'(sc_fac_r) << 32) : 66'd0) + 66'h8000;
  assign sc_r   = sc_sum >> 16;
  assign sc_t   = (sc_neg_r ? (66'd0 - sc_r) : sc_r) + {{34{sc_base_r[31]}}, sc_base_r};
  assign sc_sat = sat32($signed(sc_t));
  assign q66    = 66'(div_rsp.quot[48:0]);
  assign mean_sat = sat32(sum_r[47] ? $signed(66'd0 - q66) : $signed(q66));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NONE;
      eps_r       <= 17'd1;
    end else begin
      out_valid_r <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_MODE) mode_r <= pwdata[1:0];
        else                      eps_r  <= pwdata[16:0];
      end
      case (state_r)
        S_CLR: begin
          if (clr_r == AW'(COLUMNS - 1)) state_r <= S_IDLE;
          else                           clr_r   <= clr_r + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            in_r    <= in_data;
            bad_r   <= !col_ok;
            ov_r    <= 1'b0;
            res_r   <= '0;
            state_r <= col_ok ? S_RD : S_WB;
          end
        end
        S_RD: begin
          cnt_r   <= acc_rd.cnt;
          sum_r   <= acc_rd.sum;
          sq_r    <= acc_rd.sqsum;
          lo_r    <= acc_rd.lo;
          hi_r    <= acc_rd.hi;
          mean_r  <= stat_rd.mean;
          sd_r    <= stat_rd.sd;
          ir_r    <= stat_rd.inv_rng;
          is_r    <= stat_rd.inv_sd;
          fr_r    <= stat_rd.flr_rng;
          fs_r    <= stat_rd.flr_sd;
          state_r <= S_CMD;
        end
        S_CMD: begin
          case (cmd_t'(in_r.command))
            CMD_ACC: begin
              if (in_r.value_missing) begin
                state_r <= S_WB;
              end else if (cnt_r == 16'hFFFF) begin
                ov_r    <= 1'b1;
                state_r <= S_WB;
              end else begin
                state_r <= S_AMUL;
              end
            end
            CMD_FIN: begin
              if (!in_r.keep_scaling || cnt_r < 16'd2) begin
                if (!in_r.keep_scaling || cnt_r == 16'd0) begin
                  lo_r   <= '0;
                  hi_r   <= '0;
                  mean_r <= '0;
                end else begin
                  mean_r <= sum_r[31:0];
                end
                sd_r    <= '0;
                ir_r    <= ONE_Q;
                is_r    <= ONE_Q;
                fr_r    <= ONE_Q;
                fs_r    <= ONE_Q;
                state_r <= S_WB;
              end else begin
                state_r <= S_F1;
              end
            end
            CMD_SCALE, CMD_UPSCALE: begin
              if (in_r.value_missing) begin
                state_r <= S_WB;
              end else if (mode == MODE_NONE) begin
                res_r   <= v;
                state_r <= S_WB;
              end else begin
                if (cmd_t'(in_r.command) == CMD_SCALE) begin
                  sc_neg_r  <= a33[32];
                  sc_hi_r   <= amag[32];
                  sc_mag_r  <= amag[31:0];
                  sc_fac_r  <= (mode == MODE_STD) ? is_r : ir_r;
                  sc_base_r <= '0;
                end else begin
                  sc_neg_r  <= v[31];
                  sc_hi_r   <= 1'b0;
                  sc_mag_r  <= vmag;
                  sc_fac_r  <= (mode == MODE_STD) ? fs_r : fr_r;
                  sc_base_r <= base_c;
                end
                state_r <= S_SMUL;
              end
            end
            CMD_CLEAR: begin
              cnt_r   <= '0;
              sum_r   <= '0;
              sq_r    <= '0;
              lo_r    <= MAX32;
              hi_r    <= MIN32;
              mean_r  <= '0;
              sd_r    <= '0;
              ir_r    <= ONE_Q;
              is_r    <= ONE_Q;
              fr_r    <= ONE_Q;
              fs_r    <= ONE_Q;
              state_r <= S_WB;
            end
            default: state_r <= S_WB;
          endcase
        end
        S_AMUL: state_r <= S_AUPD;
        S_AUPD: begin
          cnt_r <= cnt_r + 16'd1;
          sum_r <= sum_r + {{16{v[31]}}, v};
          sq_r  <= sq_r + ((prod_r + 64'h8000) >> 16);
          if (v < lo_r) lo_r <= v;
          if (v > hi_r) hi_r <= v;
          state_r <= S_WB;
        end
        S_SMUL: state_r <= S_SUPD;
        S_SUPD: begin
          res_r   <= sc_sat.val;
          ov_r    <= sc_sat.ov;
          state_r <= S_WB;
        end
        S_F1: state_r <= S_F2;
        S_F2: begin
          p_r     <= 96'(prod_r);
          state_r <= S_F3;
        end
        S_F3: begin
          p_r     <= p_r + 96'({prod_r, 33'd0});
          state_r <= S_F4;
        end
        S_F4: begin
          p_r     <= p_r + {prod_r[31:0], 64'd0};
          state_r <= S_FDM;
        end
        S_FDM: begin
          if (div_rsp.done) begin
            mean_r  <= mean_sat.val;
            ov_r    <= ov_r | mean_sat.ov;
            state_r <= S_FDT;
          end
        end
        S_FDT: begin
          if (div_rsp.done) state_r <= S_FDV;
        end
        S_FDV: begin
          if (div_rsp.done) begin
            if (var_c[63:46] != '0) begin
              sd_r    <= MAX32;
              ov_r    <= 1'b1;
              state_r <= S_FFL;
            end else begin
              x_r     <= {var_c[47:0], 16'd0};
              root_r  <= '0;
              k_r     <= 5'd31;
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          x_r    <= x_nxt;
          root_r <= root_nxt;
          k_r    <= k_r - 5'd1;
          if (k_r == 5'd0) begin
            sd_r    <= root_nxt[31:0];
            state_r <= S_FFL;
          end
        end
        S_FFL: begin
          fr_r    <= fr_c;
          fs_r    <= fs_c;
          state_r <= S_FDR;
        end
        S_FDR: begin
          if (div_rsp.done) begin
            if (div_rsp.quot[DIV_W-1:32] != '0) begin
              ir_r <= 32'hFFFF_FFFF;
              ov_r <= 1'b1;
            end else begin
              ir_r <= div_rsp.quot[31:0];
            end
            state_r <= S_FDS;
          end
        end
        S_FDS: begin
          if (div_rsp.done) begin
            if (div_rsp.quot[DIV_W-1:32] != '0) begin
              is_r <= 32'hFFFF_FFFF;
              ov_r <= 1'b1;
            end else begin
              is_r <= div_rsp.quot[31:0];
            end
            state_r <= S_WB;
          end
        end
        S_WB: begin
          out_valid_r <= 1'b1;
          if (bad_r) begin
            out_r <= '0;
          end else begin
            out_r.result_value <= res_r;
            out_r.count_out    <= cnt_r;
            out_r.mean_out     <= mean_r;
            out_r.stdev_out    <= sd_r[30:0];
            out_r.min_out      <= lo_r;
            out_r.max_out      <= hi_r;
            out_r.overflow     <= ov_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_MODE) ? 32'(mode_r) : 32'(eps_r);

  a_wb_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_valid) else $error("write-back without result word");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result word repeated");
  a_sd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_WB) |-> !stat_wdata.sd[31]) else $error("stdev out of range");
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WB || state_r == S_CLR)) else $error("stray memory write");

endmodule
